// File: hdl/calendar_day_number_converter_macros.svh
// ---------------------------------------------------------------------------
// Calendar day number converter assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ---------------------------------------------------------------------------
`ifndef CALENDAR_DAY_NUMBER_CONVERTER_MACROS_SVH
`define CALENDAR_DAY_NUMBER_CONVERTER_MACROS_SVH

// same-cycle implication
`define CDN_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cdn: same-cycle check failed");

// next-cycle implication
`define CDN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cdn: next-cycle check failed");

`endif

// File: hdl/cdn_pkg.sv
// ---------------------------------------------------------------------------
// Calendar day number converter package
// Payload types, controller/datapath interface types and fixed constants.
// ---------------------------------------------------------------------------
package cdn_pkg;

   // internal widths: years up to 10000, absolute day counts up to ~3.7M
   localparam int YEAR_W  = 14;
   localparam int DAY_W   = 22;
   localparam int DN_W    = 19;
   localparam int DOY_W   = 9;
   localparam int PA_W    = YEAR_W - 2;
   localparam int QC_W    = 8;
   localparam int EST_Q_W = 11;

   localparam int DN_MAX_INT = 524287;

   // n / 366, rounded down so the year estimate never overshoots
   localparam int              RECIP366_SHIFT = 28;
   localparam logic [19:0]     RECIP366 = 20'((64'd1 << RECIP366_SHIFT) / 64'd366);
   // x / 25, rounded up; exact floor for x below 4096
   localparam int              RECIP25_SHIFT = 15;
   localparam logic [10:0]     RECIP25 = 11'(((32'd1 << RECIP25_SHIFT) / 32'd25) + 32'd1);

   localparam logic [DOY_W-1:0] DAYS_IN_YEAR   = 9'd365;
   localparam logic [3:0]       LAST_MONTH_IDX = 4'd11;
   localparam logic [3:0]       MONTH_DEC      = 4'd12;
   localparam logic [4:0]       DAY_LAST       = 5'd31;

   typedef enum logic [1:0] {
      OP_DATE_TO_NUM = 2'd0,
      OP_NUM_TO_DATE = 2'd1,
      OP_DOY_TO_DATE = 2'd2,
      OP_UNUSED      = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [11:0] year_in;
      logic [3:0]  month_in;
      logic [4:0]  day_in;
      logic [8:0]  day_of_year_in;
      logic [18:0] day_number_in;
   } req_type;

   typedef struct packed {
      logic [18:0] day_number_out;
      logic [8:0]  day_of_year_out;
      logic [11:0] year_out;
      logic [3:0]  month_out;
      logic [4:0]  day_out;
      logic        status;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EST,
      S_YMUL,
      S_YADD,
      S_PROBE,
      S_FMUL,
      S_FADD,
      S_SETDOY,
      S_RANGE,
      S_MSTEP,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic est;
      logic ymul;
      logic yadd;
      logic year_inc;
      logic year_dec;
      logic set_doy;
      logic range_chk;
      logic mstep;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      op_type op;
      logic   below;
      logic   over;
      logic   more;
   } dp_stat_type;

   // month length by zero-based month index
   function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
      logic [4:0] len;
      begin
         case (idx)
            4'd0:    len = 5'd31;
            4'd1:    len = 5'd28 + {4'b0, leap};
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            4'd11:   len = 5'd31;
            default: len = 5'd0;
         endcase
         return len;
      end
   endfunction

endpackage

// File: hdl/cdn_ctrl.sv
// ---------------------------------------------------------------------------
// Calendar day number converter controller
// Sequences the year unit, the year search and the month stepper.
// ---------------------------------------------------------------------------
module cdn_ctrl import cdn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  op_type      req_op,
   input  dp_stat_type dp_stat,
   output logic        busy,
   output dp_cmd_type  dp_cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_op)
                  OP_NUM_TO_DATE: state_in = S_EST;
                  OP_UNUSED:      state_in = S_FINISH;
                  default:        state_in = S_YMUL;
               endcase
            end
         end
         S_EST:  state_in = S_YMUL;
         S_YMUL: state_in = S_YADD;
         S_YADD: begin
            case (dp_stat.op)
               OP_NUM_TO_DATE: state_in = S_PROBE;
               OP_DOY_TO_DATE: state_in = S_RANGE;
               default:        state_in = S_MSTEP;
            endcase
         end
         S_PROBE:  state_in = dp_stat.below ? S_YMUL : S_FMUL;
         S_FMUL:   state_in = S_FADD;
         S_FADD:   state_in = S_SETDOY;
         S_SETDOY: state_in = S_MSTEP;
         S_RANGE:  state_in = dp_stat.over ? S_FINISH : S_MSTEP;
         S_MSTEP:  state_in = dp_stat.more ? S_MSTEP : S_IDLE;
         S_FINISH: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      dp_cmd = '0;
      busy   = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE:   dp_cmd.load = start;
         S_EST:    dp_cmd.est = 1'b1;
         S_YMUL:   dp_cmd.ymul = 1'b1;
         S_YADD:   dp_cmd.yadd = 1'b1;
         S_PROBE: begin
            dp_cmd.year_inc = dp_stat.below;
            dp_cmd.year_dec = !dp_stat.below;
         end
         S_FMUL:   dp_cmd.ymul = 1'b1;
         S_FADD:   dp_cmd.yadd = 1'b1;
         S_SETDOY: dp_cmd.set_doy = 1'b1;
         // latch the range flag; the finish state or the month stepper emits the result
         S_RANGE:  dp_cmd.range_chk = 1'b1;
         S_MSTEP: begin
            dp_cmd.mstep  = dp_stat.more;
            dp_cmd.finish = !dp_stat.more;
         end
         S_FINISH: dp_cmd.finish = 1'b1;
         default:  dp_cmd = '0;
      endcase
   end

endmodule

// File: hdl/cdn_datapath.sv
// ---------------------------------------------------------------------------
// Calendar day number converter datapath
// Year unit (day count and leap flag), year search and month stepper.
// ---------------------------------------------------------------------------
module cdn_datapath import cdn_pkg::*; #(
   parameter int FIRST_YEAR = 1582,
   parameter int LAST_YEAR  = 2382
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  dp_cmd_type  dp_cmd,
   output dp_stat_type dp_stat,
   output logic        rsp_strobe,
   output rsp_type     rsp_data
);

   // days before 1-jan of a year, counted from 1-jan of year 1
   localparam int D_FIRST = 365 * (FIRST_YEAR - 1) + (FIRST_YEAR - 1) / 4
                            - (FIRST_YEAR - 1) / 100 + (FIRST_YEAR - 1) / 400;
   localparam int D_END   = 365 * LAST_YEAR + LAST_YEAR / 4
                            - LAST_YEAR / 100 + LAST_YEAR / 400;
   localparam int SPAN    = D_END - D_FIRST;
   localparam int LIM_INT = (SPAN > DN_MAX_INT) ? DN_MAX_INT : SPAN;

   localparam logic [DAY_W-1:0]  D_FIRST_V = DAY_W'(D_FIRST);
   localparam logic [DN_W-1:0]   LIM_V     = DN_W'(LIM_INT);
   localparam logic [YEAR_W-1:0] FIRST_V   = YEAR_W'(FIRST_YEAR);
   localparam logic [YEAR_W-1:0] LAST_V    = YEAR_W'(LAST_YEAR);

   op_type             op_ff, op_in;
   logic               ylo_ff, ylo_in;
   logic               yhi_ff, yhi_in;
   logic               mbad_ff, mbad_in;
   logic               clamp_ff, clamp_in;
   logic               over_ff, over_in;
   logic [3:0]         mon_ff, mon_in;
   logic [YEAR_W-1:0]  y_ff, y_in;
   logic [DN_W-1:0]    n_ff, n_in;
   logic [DAY_W-1:0]   aidx_ff, aidx_in;
   logic [DAY_W-1:0]   m365_ff, m365_in;
   logic [DAY_W-1:0]   d_ff, d_in;
   logic [QC_W-1:0]    qa_ff, qa_in;
   logic [QC_W-1:0]    qb_ff, qb_in;
   logic               leap_ff, leap_in;
   logic [DOY_W-1:0]   cnt_ff, cnt_in;
   logic [3:0]         mi_ff, mi_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_strobe_ff, rsp_strobe_in;

   logic [YEAR_W-1:0]       year_m1;
   logic [PA_W-1:0]         pa;
   logic [PA_W-1:0]         pb;
   logic [PA_W+10:0]        qa_prod;
   logic [PA_W+10:0]        qb_prod;
   logic [15:0]             century_y;
   logic [DN_W-1:0]         nm1;
   logic [DN_W+19:0]        est_prod;
   logic [EST_Q_W-1:0]      q366;
   logic [4:0]              mlen;
   logic [DOY_W-1:0]        mlen9;
   logic [DAY_W-1:0]        doy_wide;
   logic [DAY_W-1:0]        rel;
   logic [YEAR_W-1:0]       yin;
   logic                    more_acc;
   logic                    more_split;

   // ---- year unit, first half: products and century quotients
   assign year_m1 = y_ff - YEAR_W'(1);
   assign pa      = year_m1[YEAR_W-1:2];
   assign pb      = y_ff[YEAR_W-1:2];
   assign qa_prod = {11'b0, pa} * {{PA_W{1'b0}}, RECIP25};
   assign qb_prod = {11'b0, pb} * {{PA_W{1'b0}}, RECIP25};

   // ---- year unit, second half: leap test
   assign century_y = {{(16-QC_W){1'b0}}, qb_ff} * 16'd100;

   // ---- year estimate from the day number
   assign nm1      = n_ff - DN_W'(1);
   assign est_prod = {20'b0, nm1} * {{DN_W{1'b0}}, RECIP366};
   assign q366     = est_prod[RECIP366_SHIFT +: EST_Q_W];

   // ---- month stepper
   assign mlen       = month_len(mi_ff, leap_ff);
   assign mlen9      = {{(DOY_W-5){1'b0}}, mlen};
   assign more_acc   = (mi_ff + 4'd1) < mon_ff;
   assign more_split = (mi_ff < LAST_MONTH_IDX) && (cnt_ff > mlen9);

   assign doy_wide = aidx_ff - d_ff + DAY_W'(1);
   assign rel      = d_ff - D_FIRST_V + {{(DAY_W-DOY_W){1'b0}}, cnt_ff};
   assign yin      = {{(YEAR_W-12){1'b0}}, req_data.year_in};

   always_comb begin
      dp_stat.op    = op_ff;
      dp_stat.below = (d_ff <= aidx_ff);
      dp_stat.over  = cnt_ff > (DAYS_IN_YEAR + {{(DOY_W-1){1'b0}}, leap_ff});
      dp_stat.more  = (op_ff == OP_DATE_TO_NUM) ? more_acc : more_split;
   end

   always_comb begin
      op_in         = op_ff;
      ylo_in        = ylo_ff;
      yhi_in        = yhi_ff;
      mbad_in       = mbad_ff;
      clamp_in      = clamp_ff;
      over_in       = over_ff;
      mon_in        = mon_ff;
      y_in          = y_ff;
      n_in          = n_ff;
      aidx_in       = aidx_ff;
      m365_in       = m365_ff;
      d_in          = d_ff;
      qa_in         = qa_ff;
      qb_in         = qb_ff;
      leap_in       = leap_ff;
      cnt_in        = cnt_ff;
      mi_in         = mi_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = dp_cmd.finish;

      if (dp_cmd.load) begin
         op_in    = op_type'(req_data.cmd);
         y_in     = yin;
         ylo_in   = yin < FIRST_V;
         yhi_in   = yin > LAST_V;
         mi_in    = 4'd0;
         over_in  = 1'b0;
         mbad_in  = (req_data.month_in == 4'd0) || (req_data.month_in > MONTH_DEC);
         if (req_data.month_in == 4'd0) begin
            mon_in = 4'd1;
         end else if (req_data.month_in > MONTH_DEC) begin
            mon_in = MONTH_DEC;
         end else begin
            mon_in = req_data.month_in;
         end
         case (op_type'(req_data.cmd))
            OP_DATE_TO_NUM: cnt_in = {{(DOY_W-5){1'b0}}, req_data.day_in};
            OP_DOY_TO_DATE: cnt_in = req_data.day_of_year_in;
            default:        cnt_in = '0;
         endcase
         // clamp the day number into the covered span
         if (req_data.day_number_in == '0) begin
            n_in     = DN_W'(1);
            clamp_in = 1'b1;
         end else if (req_data.day_number_in > LIM_V) begin
            n_in     = LIM_V;
            clamp_in = 1'b1;
         end else begin
            n_in     = req_data.day_number_in;
            clamp_in = 1'b0;
         end
      end

      // first candidate is one past the under-estimated year
      if (dp_cmd.est) begin
         y_in    = FIRST_V + {{(YEAR_W-EST_Q_W){1'b0}}, q366} + YEAR_W'(1);
         aidx_in = D_FIRST_V + {{(DAY_W-DN_W){1'b0}}, nm1};
      end

      if (dp_cmd.ymul) begin
         m365_in = {{(DAY_W-YEAR_W){1'b0}}, year_m1} * DAY_W'(DAYS_IN_YEAR);
         qa_in   = qa_prod[RECIP25_SHIFT +: QC_W];
         qb_in   = qb_prod[RECIP25_SHIFT +: QC_W];
      end

      if (dp_cmd.yadd) begin
         d_in    = m365_ff + {{(DAY_W-PA_W){1'b0}}, pa} - {{(DAY_W-QC_W){1'b0}}, qa_ff}
                   + {{(DAY_W-QC_W+2){1'b0}}, qa_ff[QC_W-1:2]};
         leap_in = (y_ff[1:0] == 2'b00)
                   && (({{(16-YEAR_W){1'b0}}, y_ff} != century_y) || (qb_ff[1:0] == 2'b00));
      end

      if (dp_cmd.year_inc) begin
         y_in = y_ff + YEAR_W'(1);
      end
      if (dp_cmd.year_dec) begin
         y_in = y_ff - YEAR_W'(1);
      end

      if (dp_cmd.set_doy) begin
         cnt_in = doy_wide[DOY_W-1:0];
      end

      if (dp_cmd.range_chk) begin
         over_in = dp_stat.over;
      end

      if (dp_cmd.mstep) begin
         cnt_in = (op_ff == OP_DATE_TO_NUM) ? (cnt_ff + mlen9) : (cnt_ff - mlen9);
         mi_in  = mi_ff + 4'd1;
      end

      if (dp_cmd.finish) begin
         rsp_in = '0;
         case (op_ff)
            OP_DATE_TO_NUM: begin
               rsp_in.day_of_year_out = cnt_ff;
               if (ylo_ff) begin
                  rsp_in.day_number_out = '0;
               end else if (yhi_ff) begin
                  rsp_in.day_number_out = LIM_V;
               end else if (rel > {{(DAY_W-DN_W){1'b0}}, LIM_V}) begin
                  rsp_in.day_number_out = LIM_V;
               end else begin
                  rsp_in.day_number_out = rel[DN_W-1:0];
               end
               rsp_in.status = mbad_ff | ylo_ff | yhi_ff;
            end
            OP_NUM_TO_DATE: begin
               rsp_in.year_out  = y_ff[11:0];
               rsp_in.month_out = mi_ff + 4'd1;
               rsp_in.day_out   = cnt_ff[4:0];
               rsp_in.status    = clamp_ff;
            end
            OP_DOY_TO_DATE: begin
               if (over_ff) begin
                  rsp_in.month_out = MONTH_DEC;
                  rsp_in.day_out   = DAY_LAST;
               end else begin
                  rsp_in.month_out = mi_ff + 4'd1;
                  rsp_in.day_out   = cnt_ff[4:0];
               end
               rsp_in.status = ylo_ff | yhi_ff | over_ff;
            end
            default: rsp_in.status = 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      ylo_ff   <= ylo_in;
      yhi_ff   <= yhi_in;
      mbad_ff  <= mbad_in;
      clamp_ff <= clamp_in;
      over_ff  <= over_in;
      mon_ff   <= mon_in;
      y_ff     <= y_in;
      n_ff     <= n_in;
      aidx_ff  <= aidx_in;
      m365_ff  <= m365_in;
      d_ff     <= d_in;
      qa_ff    <= qa_in;
      qb_ff    <= qb_in;
      leap_ff  <= leap_in;
      cnt_ff   <= cnt_in;
      mi_ff    <= mi_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// File: hdl/calendar_day_number_converter.sv
// ---------------------------------------------------------------------------
// Calendar day number converter: date to number, day of year to date and day
// number to date, the last using year probes and month steps; an unused command
// goes straight to the finish state with a failing status
// One item at a time; busy is high from accept until the result strobe, and the
// next item may be taken at the edge that takes the result
// Synchronous active-high reset returns to idle with no result pending
// ---------------------------------------------------------------------------
module calendar_day_number_converter import cdn_pkg::*; #(
   parameter int FIRST_YEAR = 1582,
   parameter int LAST_YEAR  = 2382
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   // The controller walks one item through these steps:
   //   date to number   : year unit (multiply, then add), then add month lengths one per cycle
   //   number to date   : estimate the year as (n-1)/366 (always at or below the answer),
   //                      probe the next year's start until it passes the day index,
   //                      step back one year, rerun the year unit, then split
   //                      the day of year into month and day one month per cycle
   //   day of year split: year unit, range check against the year length, then split
   // The year unit gives the day count before 1-jan of a year and its leap flag,
   // built from one 365x multiply and two reciprocal multiplies by 1/25.

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   // sequencer: decides each step from the datapath status
   cdn_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_op  (op_type'(req_data.cmd)),
      .dp_stat (dp_stat),
      .busy    (busy),
      .dp_cmd  (dp_cmd)
   );

   // datapath: holds the item, runs the year unit and the month stepper,
   // and registers the result so it shows with the strobe and holds until the next result
   cdn_datapath #(
      .FIRST_YEAR (FIRST_YEAR),
      .LAST_YEAR  (LAST_YEAR)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .dp_cmd     (dp_cmd),
      .dp_stat    (dp_stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// File: hdl/cdn_checker.sv
// ---------------------------------------------------------------------------
// Calendar day number converter port checker
// Watches the top-level ports over time; attached by bind.
// ---------------------------------------------------------------------------
`include "calendar_day_number_converter_macros.svh"

module cdn_checker import cdn_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // accepted item keeps the block busy
   `CDN_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // strobes never come back to back
   `CDN_ASSERT_NEXT(a_strobe_gap, clock, reset, rsp_strobe, !rsp_strobe)
   // leaving busy always delivers the result
   `CDN_ASSERT_IMPL(a_done_strobe, clock, reset, $fell(busy) && !$past(reset), rsp_strobe)
   // a result never carries both a day number and a year
   `CDN_ASSERT_IMPL(a_one_kind, clock, reset, rsp_strobe, rsp_data.year_out == 12'd0 || rsp_data.day_number_out == 19'd0)
   // an unused command goes through the finish state to a failing result strobe
   `CDN_ASSERT_IMPL(a_unused_fail, clock, reset, $past(start && !busy && !reset && req_data.cmd == OP_UNUSED, 2), rsp_strobe && rsp_data.status)

endmodule

bind calendar_day_number_converter cdn_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Calendar day number converter testbench
// Drives date, day-number and day-of-year conversions through the command
// port with random idle gaps, predicts each result and checks every result
// field in order of issue.
// ---------------------------------------------------------------------------
module testbench;
   import cdn_pkg::*;

   localparam int FIRST_YEAR  = 1582;
   localparam int LAST_YEAR   = 2382;
   localparam int ITEM_COUNT  = 500;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 40;

   // Predicts conversions and holds the results still owed by the block.
   class calendar_board #(int FIRST_YEAR = 1582, int LAST_YEAR = 2382);
      rsp_type pending_dates[$];
      int      month_table[12];
      int      mismatch_count;

      function new();
         month_table = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
         mismatch_count = 0;
      endfunction

      function bit is_leap(int y);
         return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      endfunction

      function int year_days(int y);
         return is_leap(y) ? 366 : 365;
      endfunction

      function int month_days(int m0, int y);
         int v;
         v = month_table[m0 % 12] & 31;
         if (m0 == 1 && is_leap(y))
            v++;
         return v;
      endfunction

      // leap years in 1 .. y-1
      function int leaps_upto(int y);
         int p;
         p = y - 1;
         return p / 4 - p / 100 + p / 400;
      endfunction

      function int days_ahead(int y);
         return 365 * (y - FIRST_YEAR) + leaps_upto(y) - leaps_upto(FIRST_YEAR);
      endfunction

      function int final_day_number();
         int v;
         v = days_ahead(LAST_YEAR + 1);
         return (v > DN_MAX_INT) ? DN_MAX_INT : v;
      endfunction

      function void split_day(int doy, int y, output int mon, output int day);
         int i;
         i = 0;
         while (i < 11 && doy > month_days(i, y)) begin
            doy -= month_days(i, y);
            i++;
         end
         mon = i + 1;
         day = doy;
      endfunction

      function rsp_type convert_date(req_type q);
         rsp_type r;
         int      year, m, i, doy, n, y, mon, day, lim;
         r    = '0;
         year = q.year_in;
         lim  = final_day_number();
         case (op_type'(q.cmd))
            OP_DATE_TO_NUM: begin
               m = q.month_in;
               if (m < 1 || m > 12)
                  r.status = 1'b1;
               if (m < 1)
                  m = 1;
               if (m > 12)
                  m = 12;
               doy = 0;
               for (i = 0; i + 1 < m; i++)
                  doy += month_days(i, year);
               doy += q.day_in;
               r.day_of_year_out = 9'(doy);
               if (year < FIRST_YEAR) begin
                  r.day_number_out = '0;
                  r.status = 1'b1;
               end else if (year > LAST_YEAR) begin
                  r.day_number_out = 19'(lim);
                  r.status = 1'b1;
               end else begin
                  n = days_ahead(year) + doy;
                  if (n > lim)
                     n = lim;
                  r.day_number_out = 19'(n);
               end
            end
            OP_NUM_TO_DATE: begin
               n = q.day_number_in;
               y = FIRST_YEAR;
               if (n < 1) begin
                  n = 1;
                  r.status = 1'b1;
               end
               if (n > lim) begin
                  n = lim;
                  r.status = 1'b1;
               end
               while (y < LAST_YEAR && n > year_days(y)) begin
                  n -= year_days(y);
                  y++;
               end
               if (n > year_days(y))
                  n = year_days(y);
               split_day(n, y, mon, day);
               r.year_out  = 12'(y);
               r.month_out = 4'(mon);
               r.day_out   = 5'(day);
            end
            OP_DOY_TO_DATE: begin
               if (year < FIRST_YEAR || year > LAST_YEAR)
                  r.status = 1'b1;
               if (q.day_of_year_in > year_days(year)) begin
                  r.month_out = 4'd12;
                  r.day_out   = 5'd31;
                  r.status    = 1'b1;
               end else begin
                  split_day(q.day_of_year_in, year, mon, day);
                  r.month_out = 4'(mon);
                  r.day_out   = 5'(day);
               end
            end
            default: r.status = 1'b1;
         endcase
         return r;
      endfunction

      function void note_request(req_type q);
         pending_dates.push_back(convert_date(q));
      endfunction

      function int outstanding();
         return pending_dates.size();
      endfunction

      task flag_mismatch(string what);
         mismatch_count++;
         $display("[%0t] mismatch: %s", $time, what);
      endtask

      task check_field(string name, int got, int want);
         if (got != want)
            flag_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (pending_dates.size() == 0) begin
            flag_mismatch("result strobe with no item outstanding");
            return;
         end
         want = pending_dates.pop_front();
         check_field("day_number_out", got.day_number_out, want.day_number_out);
         check_field("day_of_year_out", got.day_of_year_out, want.day_of_year_out);
         check_field("year_out", got.year_out, want.year_out);
         check_field("month_out", got.month_out, want.month_out);
         check_field("day_out", got.day_out, want.day_out);
         check_field("status", got.status, want.status);
      endtask
   endclass

   typedef calendar_board #(.FIRST_YEAR(FIRST_YEAR), .LAST_YEAR(LAST_YEAR)) board_type;

   logic    clock      = 1'b0;
   logic    reset      = 1'b1;
   logic    start      = 1'b0;
   req_type req_data   = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   board_type board = new();
   int        cycle_count = 0;
   int        last_dn;

   calendar_day_number_converter #(
      .FIRST_YEAR(FIRST_YEAR),
      .LAST_YEAR (LAST_YEAR)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // Abort a hung run: a correct run stays far below this count.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // Check each strobed result against the oldest outstanding item.
   // Sample at the edge, so the values seen are the ones held over the cycle.
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         board.check_result(rsp_data);
   end

   function automatic req_type make_req(op_type op, int year, int month, int day,
                                        int doy, int dn);
      req_type q;
      q.cmd            = op;
      q.year_in        = 12'(year);
      q.month_in       = 4'(month);
      q.day_in         = 5'(day);
      q.day_of_year_in = 9'(doy);
      q.day_number_in  = 19'(dn);
      return q;
   endfunction

   // Random bits over the whole payload.
   function automatic req_type noise_bits();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[$bits(req_type)-1:0];
   endfunction

   // Mostly well-formed conversions with random content; the rest is raw
   // bits so that every field bit and every out-of-range path gets hit.
   function automatic req_type random_request();
      req_type q;
      q = noise_bits();
      if ($urandom_range(99) < 4)
         q.cmd = OP_UNUSED;
      else
         q.cmd = 2'($urandom_range(2));
      if ($urandom_range(99) < 85) begin
         q.year_in        = 12'($urandom_range(LAST_YEAR, FIRST_YEAR));
         q.month_in       = 4'($urandom_range(12, 1));
         q.day_in         = 5'($urandom_range(31, 1));
         q.day_of_year_in = 9'($urandom_range(366, 1));
         q.day_number_in  = 19'($urandom_range(last_dn, 1));
      end
      return q;
   endfunction

   // Offer one item and hold it until the block takes it. Idle cycles drop
   // start and put noise on the payload, which the block must ignore.
   task automatic issue(input req_type q, input bit may_idle);
      while (may_idle && $urandom_range(99) < 18) begin
         start    <= 1'b0;
         req_data <= noise_bits();
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= q;
      // busy is read before the edge updates it, so a low value here means
      // the item was taken at this edge
      do
         @(posedge clock);
      while (busy);
      board.note_request(q);
   endtask

   initial begin
      last_dn = board.final_day_number();

      // hold reset from the start, then release it on an edge
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: range ends, leap rules and each out-of-range path
      issue(make_req(OP_DATE_TO_NUM, FIRST_YEAR, 1, 1, 0, 0), 1'b1);
      issue(make_req(OP_DATE_TO_NUM, LAST_YEAR, 12, 31, 0, 0), 1'b1);
      issue(make_req(OP_DATE_TO_NUM, 2000, 2, 29, 0, 0), 1'b1);
      issue(make_req(OP_DATE_TO_NUM, 1900, 3, 0, 0, 0), 1'b1);
      issue(make_req(OP_DATE_TO_NUM, 2024, 0, 15, 0, 0), 1'b1);
      issue(make_req(OP_DATE_TO_NUM, 2100, 15, 31, 0, 0), 1'b1);
      issue(make_req(OP_DATE_TO_NUM, FIRST_YEAR - 1, 6, 10, 0, 0), 1'b1);
      issue(make_req(OP_DATE_TO_NUM, LAST_YEAR + 1, 1, 1, 0, 0), 1'b1);
      issue(make_req(OP_DATE_TO_NUM, 0, 0, 0, 0, 0), 1'b1);
      issue(make_req(OP_DATE_TO_NUM, 4095, 15, 31, 511, 524287), 1'b1);
      issue(make_req(OP_NUM_TO_DATE, 0, 0, 0, 0, 0), 1'b1);
      issue(make_req(OP_NUM_TO_DATE, 0, 0, 0, 0, 1), 1'b1);
      issue(make_req(OP_NUM_TO_DATE, 0, 0, 0, 0, last_dn), 1'b1);
      issue(make_req(OP_NUM_TO_DATE, 0, 0, 0, 0, last_dn + 1), 1'b1);
      issue(make_req(OP_NUM_TO_DATE, 4095, 15, 31, 511, 524287), 1'b1);
      issue(make_req(OP_NUM_TO_DATE, 0, 0, 0, 0, 366), 1'b1);
      issue(make_req(OP_DOY_TO_DATE, 2000, 0, 0, 366, 0), 1'b1);
      issue(make_req(OP_DOY_TO_DATE, 1900, 0, 0, 366, 0), 1'b1);
      issue(make_req(OP_DOY_TO_DATE, 2024, 0, 0, 0, 0), 1'b1);
      issue(make_req(OP_DOY_TO_DATE, 2024, 0, 0, 511, 0), 1'b1);
      issue(make_req(OP_DOY_TO_DATE, 1000, 0, 0, 60, 0), 1'b1);
      issue(make_req(OP_DOY_TO_DATE, 4095, 15, 31, 365, 524287), 1'b1);
      issue(make_req(OP_UNUSED, 4095, 15, 31, 511, 524287), 1'b1);
      issue(make_req(OP_UNUSED, 0, 0, 0, 0, 0), 1'b1);

      // random: one stretch runs back to back with no idle cycles
      for (int i = 0; i < ITEM_COUNT; i++)
         issue(random_request(), !(i >= 200 && i < 350));

      // drop start in the step of the last accept, then drain
      start <= 1'b0;
      while (board.outstanding() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (board.mismatch_count == 0 && board.outstanding() == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
